// ===== hw/rtl/shi2c_pkg.sv =====
// Shared types, constants and register indexes of the I2C slave command engine.
package shi2c_pkg;

   localparam int BufBytesDefault = 3;

   typedef enum logic [3:0] {
      MODE_ADDR_WR   = 4'd0,
      MODE_RX_ACK    = 4'd1,
      MODE_RX_NACK   = 4'd2,
      MODE_STOP      = 4'd3,
      MODE_ADDR_RD   = 4'd4,
      MODE_TX_ACK    = 4'd5,
      MODE_BUS_ERR   = 4'd6,
      MODE_TX_END    = 4'd7,
      MODE_UNSUP     = 4'd8,
      MODE_SAMPLE    = 4'd9,
      MODE_LEVEL     = 4'd10,
      MODE_LAST_WAT  = 4'd11,
      MODE_FETCH     = 4'd12
   } mode_type;

   typedef enum logic [2:0] {
      REG_CODE_MOIST = 3'd0,
      REG_CODE_LEVEL = 3'd1,
      REG_CODE_WATER = 3'd2,
      REG_CODE_LAST  = 3'd3,
      REG_CODE_LIMIT = 3'd4,
      REG_LIMIT      = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

// ===== hw/rtl/shi2c_divider.sv =====
// Bit-serial restoring divider with rounding for the moisture average.
module shi2c_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [15:0]           sum,
   input  logic [15:0]           count,
   output shi2c_pkg::div_ctrl_type ctrl,
   output logic [15:0]           quotient
);

   // Numerator is sum + count/2, up to 17 bits; one quotient bit per cycle.
   logic [16:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[16]} - {2'b00, den_ff};
      if (start) begin
         num_in  = {1'b0, sum} + {2'b00, count[15:1]};
         rem_in  = '0;
         den_in  = count;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
         end else begin
            rem_in = {rem_ff[15:0], num_ff[16]};
         end
         num_in = {num_ff[15:0], ~trial[17]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient   = num_ff[15:0];
   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != 5'd0)
      else $error("divider busy with no steps left");
   assert property (@(posedge clock) disable iff (reset) $fell(busy_ff) |-> done_ff)
      else $error("divider stopped without done");

endmodule

// ===== hw/rtl/sensor_hub_i2c_slave_command_engine.sv =====
// Top level of the sensor hub I2C slave command engine.
// Each bus, sample or host event word yields exactly one result word. An event passes
// through the work state and then the done state before its result is registered. An
// address read of the moisture average with a non-zero count stays in the work state
// while a bit-serial divider, started there, runs 17 shift steps and raises done with
// the rounded quotient. One event is handled at a time; the result register holds until
// taken, and configuration may be written at any idle time.
module sensor_hub_i2c_slave_command_engine #(
   parameter int BUF_BYTES = shi2c_pkg::BufBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // mode[3:0], data_byte[11:4], value[27:12], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // ack_next, stop_recover, tx_byte, busy_res,
                                    // cmd_pending, cmd_code, watering_amount,
                                    // moisture_sum, moisture_count, zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int IW = $clog2(BUF_BYTES + 1);
   localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam logic [IW-1:0] FULL = IW'(BUF_BYTES);

   shi2c_pkg::state_type state_ff, state_in;
   shi2c_pkg::div_ctrl_type div_ctrl;
   logic [15:0] quotient;
   logic        div_start;
   logic        divstarted_ff, divstarted_in;

   logic [7:0]  code_moist_ff, code_level_ff, code_water_ff, code_last_ff,
                code_limit_ff, limit_ff;
   logic [7:0]  buf_ff [BUF_BYTES];
   logic [IW-1:0] len_ff, len_in, idx_ff, idx_in;
   logic [7:0]  cmd_ff, cmd_in, lastw_ff, lastw_in, amount_ff, amount_in;
   logic        pend_ff, pend_in, busy_ff, busy_in;
   logic [15:0] sum_ff, sum_in, cnt_ff, cnt_in, level_ff, level_in;
   logic [3:0]  mode_ff;
   logic [7:0]  rx_ff;
   logic [15:0] val_ff;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_ff, out_in;

   // Buffer write requests from the event logic.
   logic        wr0_en, wr1_en, wrx_en;
   logic [7:0]  wr0_data, wr1_data;
   logic [AW-1:0] wrx_addr;

   logic        ack, recover;
   logic [7:0]  tx;
   logic [16:0] total;
   logic [IW-1:0] tidx;
   logic        hit_moist, hit_level, hit_water, hit_last, hit_limit;
   logic        dec_moist, dec_level, dec_water;
   logic [7:0]  dec_c;
   logic [IW-1:0] stop_len;
   logic        accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == shi2c_pkg::ST_IDLE) && !out_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   shi2c_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .sum(sum_ff), .count(cnt_ff), .ctrl(div_ctrl), .quotient(quotient)
   );

   always_comb begin
      hit_moist = cmd_ff == code_moist_ff;
      hit_level = cmd_ff == code_level_ff;
      hit_water = cmd_ff == code_water_ff;
      hit_last  = cmd_ff == code_last_ff;
      hit_limit = cmd_ff == code_limit_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         shi2c_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = shi2c_pkg::ST_DIVIDE;
            end
         end
         shi2c_pkg::ST_DIVIDE: begin
            if (!(mode_ff == shi2c_pkg::MODE_ADDR_RD && hit_moist && cnt_ff != 16'd0)
                || div_ctrl.done) begin
               state_in = shi2c_pkg::ST_DONE;
            end
         end
         shi2c_pkg::ST_DONE: state_in = shi2c_pkg::ST_IDLE;
         default: state_in = shi2c_pkg::ST_IDLE;
      endcase
   end

   // Start the divider on entering the work state for a moisture read with a non-zero count.
   assign div_start = (state_ff == shi2c_pkg::ST_DIVIDE) && !div_ctrl.busy && !div_ctrl.done
                      && mode_ff == shi2c_pkg::MODE_ADDR_RD && hit_moist
                      && cnt_ff != 16'd0 && !divstarted_ff;
   always_comb begin
      divstarted_in = divstarted_ff;
      if (state_ff != shi2c_pkg::ST_DIVIDE) divstarted_in = 1'b0;
      else if (div_start) divstarted_in = 1'b1;
   end

   // Event processing happens while the state machine is in the done state.
   always_comb begin
      len_in = len_ff; idx_in = idx_ff; cmd_in = cmd_ff; pend_in = pend_ff;
      busy_in = busy_ff; sum_in = sum_ff; cnt_in = cnt_ff; level_in = level_ff;
      lastw_in = lastw_ff; amount_in = amount_ff;
      wr0_en = 1'b0; wr1_en = 1'b0; wrx_en = 1'b0;
      wr0_data = '0; wr1_data = '0; wrx_addr = '0;
      ack = 1'b0; recover = 1'b0; tx = '0; total = '0; tidx = idx_ff;
      stop_len = idx_ff; dec_c = buf_ff[0];
      dec_moist = 1'b0; dec_level = 1'b0; dec_water = 1'b0;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (state_ff == shi2c_pkg::ST_DONE) begin
         unique case (mode_ff)
            shi2c_pkg::MODE_ADDR_WR: begin
               len_in = '0; idx_in = '0; ack = 1'b1; busy_in = 1'b1;
            end
            shi2c_pkg::MODE_RX_ACK: begin
               tidx = idx_ff;
               if (idx_ff < FULL) begin
                  wrx_en = 1'b1; wrx_addr = AW'(idx_ff); tidx = idx_ff + 1'b1;
               end
               idx_in = tidx;
               ack = ({1'b0, tidx} + 1'b1) < {1'b0, FULL};
               busy_in = 1'b1;
            end
            shi2c_pkg::MODE_RX_NACK, shi2c_pkg::MODE_STOP: begin
               tidx = idx_ff;
               if (mode_ff == shi2c_pkg::MODE_RX_NACK && idx_ff < FULL) begin
                  wrx_en = 1'b1; wrx_addr = AW'(idx_ff); tidx = idx_ff + 1'b1;
               end
               idx_in = tidx; stop_len = tidx; len_in = tidx;
               ack = 1'b1; busy_in = 1'b0;
               if (stop_len != '0) begin
                  // A byte written this same event lands in entry zero only if idx was 0.
                  dec_c = (wrx_en && idx_ff == '0) ? rx_ff : buf_ff[0];
                  cmd_in = dec_c; pend_in = 1'b1;
                  dec_moist = dec_c == code_moist_ff;
                  dec_level = dec_c == code_level_ff;
                  dec_water = dec_c == code_water_ff;
                  if (dec_moist) begin
                     sum_in = '0; cnt_in = '0;
                  end else if (dec_level) begin
                     level_in = 16'hFFFF;
                  end else if (dec_water) begin
                     lastw_in = '0;
                     if (stop_len == IW'(2)) begin
                        amount_in = (wrx_en && idx_ff == IW'(1)) ? rx_ff : buf_ff[1];
                     end else begin
                        cmd_in = '0; pend_in = 1'b0;
                     end
                  end
               end
            end
            shi2c_pkg::MODE_ADDR_RD, shi2c_pkg::MODE_TX_ACK: begin
               tidx = idx_ff;
               if (mode_ff == shi2c_pkg::MODE_ADDR_RD) begin
                  tidx = '0;
                  cmd_in = '0; pend_in = 1'b0;
                  if (hit_moist) begin
                     if (cnt_ff != 16'd0) begin
                        wr0_en = 1'b1; wr0_data = quotient[7:0];
                        wr1_en = 1'b1; wr1_data = quotient[15:8];
                        len_in = IW'(2); tx = quotient[7:0];
                     end else begin
                        wr0_en = 1'b1; wr0_data = 8'hFF; len_in = '0; tx = 8'hFF;
                     end
                  end else if (hit_level) begin
                     wr0_en = 1'b1; wr0_data = level_ff[7:0];
                     wr1_en = 1'b1; wr1_data = level_ff[15:8];
                     len_in = IW'(2); tx = level_ff[7:0];
                  end else if (hit_water || hit_last) begin
                     wr0_en = 1'b1; wr0_data = lastw_ff; len_in = IW'(1); tx = lastw_ff;
                  end else if (hit_limit) begin
                     wr0_en = 1'b1; wr0_data = limit_ff; len_in = IW'(1); tx = limit_ff;
                  end else begin
                     tx = buf_ff[0];
                  end
                  tidx = IW'(1);
               end else if (idx_ff < FULL) begin
                  tx = buf_ff[AW'(idx_ff)]; tidx = idx_ff + 1'b1;
               end else begin
                  tx = 8'hFF;
               end
               idx_in = tidx;
               ack = tidx < len_in;
               busy_in = 1'b1;
            end
            shi2c_pkg::MODE_BUS_ERR: begin
               ack = 1'b1; recover = 1'b1; busy_in = 1'b0;
            end
            shi2c_pkg::MODE_TX_END: begin
               ack = 1'b1; busy_in = 1'b0;
            end
            shi2c_pkg::MODE_UNSUP: begin
               busy_in = 1'b1;
            end
            shi2c_pkg::MODE_SAMPLE: begin
               total = {1'b0, sum_ff} + {1'b0, val_ff};
               if (total[16] || cnt_ff == 16'hFFFF) begin
                  total = {2'b00, sum_ff[15:1]} + {1'b0, val_ff};
                  cnt_in = {1'b0, cnt_ff[15:1]} + 16'd1;
               end else begin
                  cnt_in = cnt_ff + 16'd1;
               end
               sum_in = total[15:0];
            end
            shi2c_pkg::MODE_LEVEL:    level_in = val_ff;
            shi2c_pkg::MODE_LAST_WAT: lastw_in = val_ff[7:0];
            shi2c_pkg::MODE_FETCH:    pend_in = 1'b0;
            default: ;
         endcase
         out_valid_in = 1'b1;
         out_in = {4'd0, cnt_in, sum_in, amount_in, cmd_in, pend_in, busy_in, tx,
                   recover, ack};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_tdata[3:0];
         rx_ff   <= req_tdata[11:4];
         val_ff  <= req_tdata[27:12];
      end
      out_ff <= out_in;
      if (wr0_en) buf_ff[0] <= wr0_data;
      if (wr1_en) buf_ff[1] <= wr1_data;
      if (wrx_en) buf_ff[wrx_addr] <= rx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shi2c_pkg::ST_IDLE;
         divstarted_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         len_ff <= '0; idx_ff <= '0; cmd_ff <= '0; pend_ff <= 1'b0; busy_ff <= 1'b0;
         sum_ff <= '0; cnt_ff <= '0; level_ff <= '0; lastw_ff <= '0; amount_ff <= '0;
         code_moist_ff <= 8'd1; code_level_ff <= 8'd2; code_water_ff <= 8'd3;
         code_last_ff <= 8'd4; code_limit_ff <= 8'd5; limit_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         divstarted_ff <= divstarted_in;
         out_valid_ff <= out_valid_in;
         len_ff <= len_in; idx_ff <= idx_in; cmd_ff <= cmd_in; pend_ff <= pend_in;
         busy_ff <= busy_in; sum_ff <= sum_in; cnt_ff <= cnt_in; level_ff <= level_in;
         lastw_ff <= lastw_in; amount_ff <= amount_in;
         if (csr_valid && csr_ready) begin
            unique case (shi2c_pkg::reg_index_type'(csr_index))
               shi2c_pkg::REG_CODE_MOIST: code_moist_ff <= csr_data;
               shi2c_pkg::REG_CODE_LEVEL: code_level_ff <= csr_data;
               shi2c_pkg::REG_CODE_WATER: code_water_ff <= csr_data;
               shi2c_pkg::REG_CODE_LAST:  code_last_ff  <= csr_data;
               shi2c_pkg::REG_CODE_LIMIT: code_limit_ff <= csr_data;
               shi2c_pkg::REG_LIMIT:      limit_ff      <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) idx_ff <= FULL)
      else $error("byte index beyond buffer");
   assert property (@(posedge clock) disable iff (reset) len_ff <= FULL)
      else $error("message length beyond buffer");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == shi2c_pkg::ST_DONE) |=> rsp_tvalid)
      else $error("finished event without result");
   assert property (@(posedge clock) disable iff (reset)
                    div_ctrl.busy |-> state_ff == shi2c_pkg::ST_DIVIDE)
      else $error("divider running outside work state");

endmodule

// ===== dv/sensor_hub_i2c_slave_command_engine_tb.sv =====
// Self-checking testbench for the sensor hub I2C slave command engine.
`timescale 1ns / 1ps

module sensor_hub_i2c_slave_command_engine_tb;

   localparam int NBUF = shi2c_pkg::BufBytesDefault;
   localparam int WATCH_LIMIT = 3000;
   localparam int LONG_HOLD = 300;
   localparam logic [3:0] MODE_SPARE_LO = 4'd13;
   localparam logic [3:0] MODE_SPARE_HI = 4'd15;

   typedef struct packed {
      bit        ack;
      bit        recover;
      bit [7:0]  tx;
      bit        busy;
      bit        pending;
      bit [7:0]  cmd;
      bit [7:0]  amount;
      bit [15:0] sum;
      bit [15:0] count;
   } engine_result_type;

   // Keeps a private copy of the engine state and the queue of results still owed.
   class engine_scoreboard;
      bit [7:0]  codes[6];
      bit [7:0]  msg[NBUF];
      bit        written[NBUF];
      int        msg_len, index;
      bit [7:0]  cmd, last_water, amount;
      bit        pending, busy;
      bit [15:0] sum, count, level;
      engine_result_type owed[$];
      int        errors, results;

      function new();
         codes = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd0};
         foreach (msg[i]) begin
            msg[i] = 0;
            written[i] = 0;
         end
         msg_len = 0; index = 0; cmd = 0; last_water = 0; amount = 0;
         pending = 0; busy = 0; sum = 0; count = 0; level = 0;
         errors = 0; results = 0;
      endfunction

      function void write_reg(shi2c_pkg::reg_index_type r, bit [7:0] v);
         codes[r] = v;
      endfunction

      function bit known_cmd(bit [7:0] c);
         for (int i = 0; i < 5; i++)
            if (c == codes[i]) return 1;
         return 0;
      endfunction

      // True when the event would transmit a buffer entry never filled.
      function bit reads_unwritten(logic [3:0] m);
         if (m == shi2c_pkg::MODE_ADDR_RD) return !(written[0] || known_cmd(cmd));
         if (m == shi2c_pkg::MODE_TX_ACK && index < NBUF) return !written[index];
         return 0;
      endfunction

      function void put(int p, bit [7:0] b);
         msg[p] = b;
         written[p] = 1;
      endfunction

      function void add_sample(bit [15:0] v);
         int total;
         total = sum + v;
         if (total > 16'hFFFF || count == 16'hFFFF) begin
            total = (sum / 2) + v;
            count = count / 2;
         end
         sum = total[15:0];
         count = count + 1;
      endfunction

      function void load_reply();
         int avg;
         if (cmd == codes[shi2c_pkg::REG_CODE_MOIST]) begin
            if (count > 0) begin
               avg = (int'(sum) + int'(count) / 2) / int'(count);
               put(0, avg[7:0]); put(1, avg[15:8]); msg_len = 2;
            end else begin
               put(0, 8'hFF); msg_len = 0;
            end
         end else if (cmd == codes[shi2c_pkg::REG_CODE_LEVEL]) begin
            put(0, level[7:0]); put(1, level[15:8]); msg_len = 2;
         end else if (cmd == codes[shi2c_pkg::REG_CODE_WATER] ||
                      cmd == codes[shi2c_pkg::REG_CODE_LAST]) begin
            put(0, last_water); msg_len = 1;
         end else if (cmd == codes[shi2c_pkg::REG_CODE_LIMIT]) begin
            put(0, codes[shi2c_pkg::REG_LIMIT]); msg_len = 1;
         end
         cmd = 0; pending = 0;
      endfunction

      function void decode();
         if (msg_len == 0) return;
         cmd = msg[0];
         pending = 1;
         if (cmd == codes[shi2c_pkg::REG_CODE_MOIST]) begin
            sum = 0; count = 0;
         end else if (cmd == codes[shi2c_pkg::REG_CODE_LEVEL]) begin
            level = 16'hFFFF;
         end else if (cmd == codes[shi2c_pkg::REG_CODE_WATER]) begin
            last_water = 0;
            if (msg_len == 2) amount = msg[1];
            else begin
               cmd = 0; pending = 0;
            end
         end
      endfunction

      function void note_event(logic [3:0] m, bit [7:0] rx, bit [15:0] v);
         engine_result_type r;
         r = '0;
         case (m)
            shi2c_pkg::MODE_ADDR_WR: begin
               msg_len = 0; index = 0; r.ack = 1; busy = 1;
            end
            shi2c_pkg::MODE_RX_ACK: begin
               if (index < NBUF) begin put(index, rx); index++; end
               r.ack = (index + 1 < NBUF); busy = 1;
            end
            shi2c_pkg::MODE_RX_NACK, shi2c_pkg::MODE_STOP: begin
               if (m == shi2c_pkg::MODE_RX_NACK && index < NBUF) begin
                  put(index, rx); index++;
               end
               msg_len = index; r.ack = 1; decode(); busy = 0;
            end
            shi2c_pkg::MODE_ADDR_RD, shi2c_pkg::MODE_TX_ACK: begin
               if (m == shi2c_pkg::MODE_ADDR_RD) begin load_reply(); index = 0; end
               r.tx = 8'hFF;
               if (index < NBUF) begin r.tx = msg[index]; index++; end
               r.ack = (index < msg_len); busy = 1;
            end
            shi2c_pkg::MODE_BUS_ERR: begin r.ack = 1; r.recover = 1; busy = 0; end
            shi2c_pkg::MODE_TX_END: begin r.ack = 1; busy = 0; end
            shi2c_pkg::MODE_UNSUP: busy = 1;
            shi2c_pkg::MODE_SAMPLE: add_sample(v);
            shi2c_pkg::MODE_LEVEL: level = v;
            shi2c_pkg::MODE_LAST_WAT: last_water = v[7:0];
            shi2c_pkg::MODE_FETCH: pending = 0;
            default: ;
         endcase
         r.busy = busy; r.pending = pending; r.cmd = cmd; r.amount = amount;
         r.sum = sum; r.count = count;
         owed.push_back(r);
      endfunction

      function void check_result(logic [63:0] d);
         engine_result_type a, e;
         a.ack = d[0]; a.recover = d[1]; a.tx = d[9:2]; a.busy = d[10];
         a.pending = d[11]; a.cmd = d[19:12]; a.amount = d[27:20];
         a.sum = d[43:28]; a.count = d[59:44];
         results++;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", d);
            return;
         end
         e = owed.pop_front();
         if (a != e || d[63:60] != 0) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: exp ack%0d rec%0d tx%h busy%0d pend%0d cmd%h amt%h sum%h cnt%h",
                        e.ack, e.recover, e.tx, e.busy, e.pending, e.cmd, e.amount, e.sum,
                        e.count);
               $display("          got ack%0d rec%0d tx%h busy%0d pend%0d cmd%h amt%h sum%h cnt%h",
                        a.ack, a.recover, a.tx, a.busy, a.pending, a.cmd, a.amount, a.sum,
                        a.count);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tready;
   logic [31:0] req_tdata = 0;
   logic        rsp_tvalid, rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 0, csr_ready;
   logic [2:0]  csr_index = 0;
   logic [7:0]  csr_data = 0;

   engine_scoreboard board = new();
   bit idling = 1;
   bit hold_request = 0;
   int hold_left = 0, gap_left = 0;
   int quiet_cycles = 0;
   int events_sent = 0;

   sensor_hub_i2c_slave_command_engine DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request <= 0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else if (gap_left > 0) begin
         gap_left--;
         rsp_tready <= 0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         gap_left = $urandom_range(0, 4);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                     (csr_valid && csr_ready)))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("watchdog expired with %0d results owed", board.owed.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_event(logic [3:0] m, bit [7:0] rx = 0, bit [15:0] v = 0);
      if (board.reads_unwritten(m)) m = shi2c_pkg::MODE_TX_END;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {4'b0, v, rx, m};
      do @(posedge clock); while (!req_tready);
      board.note_event(m, rx, v);
      events_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 0;
      while (board.owed.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task automatic write_csr(shi2c_pkg::reg_index_type r, bit [7:0] v);
      csr_valid = 1;
      csr_index = r;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(r, v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic bit [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic bit [7:0] pick_command();
      if ($urandom_range(0, 7) == 0) return rand_byte();
      return board.codes[$urandom_range(0, 4)];
   endfunction

   function automatic bit [15:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 16'hFFFF - 16'($urandom_range(0, 3));
         1: return 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic write_transfer(int nbytes);
      send_event(shi2c_pkg::MODE_ADDR_WR);
      for (int i = 0; i < nbytes; i++)
         send_event(shi2c_pkg::MODE_RX_ACK, (i == 0) ? pick_command() : rand_byte());
      case ($urandom_range(0, 9))
         0, 1: send_event(shi2c_pkg::MODE_RX_NACK, rand_byte());
         2: send_event(shi2c_pkg::MODE_BUS_ERR);
         default: send_event(shi2c_pkg::MODE_STOP);
      endcase
   endtask

   task automatic read_transfer();
      send_event(shi2c_pkg::MODE_ADDR_RD);
      repeat ($urandom_range(0, 4)) send_event(shi2c_pkg::MODE_TX_ACK);
      send_event($urandom_range(0, 3) == 0 ? shi2c_pkg::MODE_STOP : shi2c_pkg::MODE_TX_END);
   endtask

   task automatic random_traffic(int n);
      int stop_at;
      stop_at = events_sent + n;
      while (events_sent < stop_at) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: write_transfer($urandom_range(0, 4));
            7, 8, 9, 10: read_transfer();
            11, 12, 13: send_event(shi2c_pkg::MODE_SAMPLE, rand_byte(), pick_value());
            14: send_event(shi2c_pkg::MODE_LEVEL, rand_byte(), pick_value());
            15: send_event(shi2c_pkg::MODE_LAST_WAT, rand_byte(), pick_value());
            16: send_event(shi2c_pkg::MODE_FETCH, rand_byte(), pick_value());
            default: send_event(4'($urandom_range(0, 15)), rand_byte(),
                                16'($urandom_range(0, 65535)));
         endcase
      end
   endtask

   task automatic program_codes(bit [7:0] a, bit [7:0] b, bit [7:0] c, bit [7:0] d,
                                bit [7:0] e, bit [7:0] lim);
      write_csr(shi2c_pkg::REG_CODE_MOIST, a);
      write_csr(shi2c_pkg::REG_CODE_LEVEL, b);
      write_csr(shi2c_pkg::REG_CODE_WATER, c);
      write_csr(shi2c_pkg::REG_CODE_LAST, d);
      write_csr(shi2c_pkg::REG_CODE_LIMIT, e);
      write_csr(shi2c_pkg::REG_LIMIT, lim);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part on the reset codes.
      send_event(shi2c_pkg::MODE_STOP);                 // stop with nothing received
      send_event(shi2c_pkg::MODE_ADDR_RD);              // no command: read of unfilled buffer goes out as transmit end
      send_event(shi2c_pkg::MODE_ADDR_WR);
      send_event(shi2c_pkg::MODE_RX_ACK, 8'd1);
      send_event(shi2c_pkg::MODE_STOP);                 // moisture request clears sums
      send_event(shi2c_pkg::MODE_ADDR_RD);              // empty average replies 0xFF
      send_event(shi2c_pkg::MODE_SAMPLE, 8'hFF, 16'hFFFF);
      send_event(shi2c_pkg::MODE_SAMPLE, 8'h00, 16'hFFFF); // overflow halves sum and count
      send_event(shi2c_pkg::MODE_SAMPLE, 8'hA5, 16'h0000);
      send_event(shi2c_pkg::MODE_LEVEL, 8'h5A, 16'h8001);
      send_event(shi2c_pkg::MODE_LAST_WAT, 8'h00, 16'hFFC3);
      send_event(shi2c_pkg::MODE_ADDR_WR);
      send_event(shi2c_pkg::MODE_RX_ACK, 8'd3);
      send_event(shi2c_pkg::MODE_STOP);                 // watering without an amount
      write_transfer(0);
      send_event(shi2c_pkg::MODE_ADDR_WR);
      send_event(shi2c_pkg::MODE_RX_ACK, 8'd3);
      send_event(shi2c_pkg::MODE_RX_ACK, 8'hFF);
      send_event(shi2c_pkg::MODE_RX_ACK, 8'h00);
      send_event(shi2c_pkg::MODE_RX_NACK, 8'h77);       // receive overrun drops the byte
      send_event(shi2c_pkg::MODE_ADDR_RD);
      repeat (4) send_event(shi2c_pkg::MODE_TX_ACK);    // transmit overrun sends 0xFF
      send_event(shi2c_pkg::MODE_FETCH);
      send_event(shi2c_pkg::MODE_BUS_ERR);
      send_event(shi2c_pkg::MODE_UNSUP);
      send_event(MODE_SPARE_LO, 8'hFF, 16'hFFFF);
      send_event(MODE_SPARE_HI);
      random_traffic(150);
      drain();

      program_codes(8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd255);
      random_traffic(100);
      // The receiver stops for a long stretch while events keep coming.
      hold_request = 1;
      random_traffic(60);
      drain();
      random_traffic(60);

      drain();
      program_codes(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
      random_traffic(180);
      drain();
      program_codes(8'd7, 8'd7, 8'd9, 8'd9, 8'd7, rand_byte());
      random_traffic(180);
      drain();
      program_codes(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                    rand_byte());
      random_traffic(180);
      drain();
      idling = 0;
      program_codes(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'hA5);
      random_traffic(200);
      drain();

      $display("%0d events sent, %0d results checked, over six register settings",
               events_sent, board.results);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results missing", board.errors, board.owed.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
